### sv/jtr_pkg.sv
// ----------------------------------------------------------------------------
// jtr_pkg
// Types and constants for the transport-protocol reassembler.
// ----------------------------------------------------------------------------
package jtr_pkg;

  localparam logic [23:0] PGN_CM   = 24'h00EC00;
  localparam logic [23:0] PGN_DT   = 24'h00EB00;
  localparam logic [7:0]  PF_PDU2  = 8'd240;
  localparam logic [7:0]  CTRL_BAM = 8'd32;
  localparam logic [7:0]  CTRL_RTS = 8'd16;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_STARTED  = 3'd1,
    ST_SEGMENT  = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_SINGLE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_OUT
  } fsm_t;

  typedef struct packed {
    logic [23:0] pgn;
    logic [15:0] size;
    logic [7:0]  pkt_exp;
    logic [7:0]  pkt_seen;
    logic [15:0] bytes_seen;
    logic [28:0] header;
    logic [47:0] time_us;
  } sess_t;

endpackage

### sv/j1939_transport_reassembler.sv
// ----------------------------------------------------------------------------
// j1939_transport_reassembler
// Reassembles transport-protocol sessions per source address and passes other frames through as single results.
// ----------------------------------------------------------------------------
// A word is captured in the input registers, its session record is read into
// rd, then the session memory is modified and written back with the result
// register load, which waits while out_stall holds the previous result. Input
// is stalled until the return to idle, so only one word is in flight at a time.
// Reset: clears the state machine, output valid and all session open bits
// at once; session records are undefined until written.
module j1939_transport_reassembler #(
  parameter int SOURCES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [28:0] frame_id,
  input  logic        is_extended,
  input  logic        is_error,
  input  logic        is_remote,
  input  logic [3:0]  frame_length,
  input  logic [63:0] frame_data,
  input  logic [47:0] timestamp_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [23:0] pgn,
  output logic [28:0] header_id,
  output logic [2:0]  priority_res,
  output logic [7:0]  source_address,
  output logic [7:0]  dest_address,
  output logic        is_pdu1,
  output logic [63:0] payload_bytes,
  output logic [3:0]  payload_count,
  output logic [15:0] total_size,
  output logic [47:0] start_time_us
);

  localparam int AW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  jtr_pkg::fsm_t state, state_next;
  jtr_pkg::sess_t mem [SOURCES];
  jtr_pkg::sess_t rd;
  logic [SOURCES-1:0] open_bits;

  logic [28:0] id_r;
  logic        ok_r;
  logic [3:0]  len_r;
  logic [63:0] data_r;
  logic [47:0] ts_r;

  logic [7:0]  pf, sa;
  logic [23:0] mpgn;
  logic        in_range, sess_open;
  logic [AW-1:0] idx;
  logic        accept, finish;

  assign accept = in_valid && !in_stall;

  always_comb begin
    in_stall = (state != jtr_pkg::FSM_IDLE);
    state_next = state;
    case (state)
      jtr_pkg::FSM_IDLE: if (in_valid) state_next = jtr_pkg::FSM_READ;
      jtr_pkg::FSM_READ: state_next = jtr_pkg::FSM_OUT;
      jtr_pkg::FSM_OUT:  if (!out_valid || !out_stall) state_next = jtr_pkg::FSM_IDLE;
      default: state_next = jtr_pkg::FSM_IDLE;
    endcase
  end

  assign finish = (state == jtr_pkg::FSM_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) state <= jtr_pkg::FSM_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r   <= frame_id;
      ok_r   <= is_extended && !is_error && !is_remote;
      len_r  <= frame_length;
      data_r <= frame_data;
      ts_r   <= timestamp_us;
    end
  end

  assign pf = id_r[23:16];
  assign sa = id_r[7:0];
  assign mpgn = {6'd0, id_r[25], id_r[24], pf, (pf >= jtr_pkg::PF_PDU2) ? id_r[15:8] : 8'd0};
  assign in_range = ({24'd0, sa} < 32'(SOURCES));
  assign idx = AW'(sa);
  assign sess_open = in_range && open_bits[idx];

  always_ff @(posedge clk) begin
    if (state == jtr_pkg::FSM_READ) rd <= mem[AW'(id_r[7:0])];
  end

  jtr_pkg::sess_t wr;
  logic        wr_en, set_open, clr_open;
  logic [2:0]  st;
  logic [23:0] o_pgn;
  logic [28:0] o_hdr;
  logic        o_pdu1;
  logic [63:0] o_pay;
  logic [3:0]  o_cnt;
  logic [15:0] o_tot;
  logic [47:0] o_ts;
  logic [15:0] room;
  logic [3:0]  take;
  logic [15:0] bs_new;
  logic [7:0]  ps_new;
  logic [3:0]  n;
  logic        done;

  always_comb begin
    wr = rd; wr_en = 1'b0; set_open = 1'b0; clr_open = 1'b0;
    st = jtr_pkg::ST_IGNORED; o_pgn = '0; o_hdr = '0; o_pdu1 = 1'b0;
    o_pay = '0; o_cnt = '0; o_tot = '0; o_ts = '0;
    room = (rd.bytes_seen < rd.size) ? rd.size - rd.bytes_seen : 16'd0;
    take = (room > 16'd7) ? 4'd7 : room[3:0];
    bs_new = rd.bytes_seen + {12'd0, take};
    ps_new = rd.pkt_seen + 8'd1;
    done = (ps_new >= rd.pkt_exp) || (bs_new >= rd.size);
    n = (len_r > 4'd8) ? 4'd8 : len_r;
    if (ok_r) begin
      if (mpgn == jtr_pkg::PGN_CM) begin
        if (len_r >= 4'd8 && in_range &&
            (data_r[7:0] == jtr_pkg::CTRL_BAM || data_r[7:0] == jtr_pkg::CTRL_RTS)) begin
          wr.size = data_r[23:8]; wr.pkt_exp = data_r[31:24];
          wr.pgn = data_r[63:40]; wr.pkt_seen = '0; wr.bytes_seen = '0;
          wr.header = id_r; wr.time_us = ts_r;
          wr_en = 1'b1; set_open = 1'b1;
          st = jtr_pkg::ST_STARTED; o_pgn = data_r[63:40]; o_hdr = id_r; o_ts = ts_r;
        end
      end else if (mpgn == jtr_pkg::PGN_DT) begin
        if (sess_open) begin
          wr.pkt_seen = ps_new; wr.bytes_seen = bs_new; wr_en = 1'b1;
          clr_open = done;
          st = done ? jtr_pkg::ST_COMPLETE : jtr_pkg::ST_SEGMENT;
          o_pgn = rd.pgn; o_hdr = rd.header; o_ts = rd.time_us;
          o_pay = {8'd0, data_r[63:8]} & ~(64'hFFFF_FFFF_FFFF_FFFF << {take, 3'b000});
          o_cnt = take;
          o_tot = done ? bs_new : 16'd0;
        end
      end else begin
        st = jtr_pkg::ST_SINGLE; o_pgn = mpgn; o_hdr = id_r; o_ts = ts_r;
        o_pdu1 = (pf < jtr_pkg::PF_PDU2);
        o_pay = (n == 4'd8) ? data_r : data_r & ~(64'hFFFF_FFFF_FFFF_FFFF << {n, 3'b000});
        o_cnt = n; o_tot = {12'd0, n};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish && wr_en) mem[idx] <= wr;
  end

  always_ff @(posedge clk) begin
    if (rst) open_bits <= '0;
    else if (finish && set_open) open_bits[idx] <= 1'b1;
    else if (finish && clr_open) open_bits[idx] <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status <= st; pgn <= o_pgn; header_id <= o_hdr;
      priority_res <= o_hdr[28:26]; source_address <= o_hdr[7:0];
      dest_address <= o_hdr[15:8]; is_pdu1 <= o_pdu1; payload_bytes <= o_pay;
      payload_count <= o_cnt; total_size <= o_tot; start_time_us <= o_ts;
    end
  end

endmodule

### sv/jtr_checker.sv
// ----------------------------------------------------------------------------
// jtr_checker
// Port-level checks on the reassembler, bound to every reassembler instance.
// ----------------------------------------------------------------------------
module jtr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [3:0]  payload_count,
  input logic [15:0] total_size,
  input logic        is_pdu1
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken straight after the first");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> payload_count <= 4'd8)
    else $error("payload count above eight");

  a_ignored: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == jtr_pkg::ST_IGNORED |->
      payload_count == 4'd0 && total_size == 16'd0 && !is_pdu1)
    else $error("ignored word carries data");

endmodule

bind j1939_transport_reassembler jtr_checker u_jtr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .payload_count(payload_count), .total_size(total_size), .is_pdu1(is_pdu1)
);

### sim/tb_j1939_transport_reassembler.sv
// ----------------------------------------------------------------------------
// tb_j1939_transport_reassembler
// Drives CAN frames into the transport-protocol reassembler with random
// idling and a long output hold-off, predicts each result with a model of the
// per-source session table and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_j1939_transport_reassembler;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [28:0] id;
    logic        ext;
    logic        err;
    logic        rem;
    logic [3:0]  len;
    logic [63:0] data;
    logic [47:0] ts;
  } frame_s;

  typedef struct {
    jtr_pkg::status_t st;
    logic [23:0] pgn;
    logic [28:0] hdr;
    logic [2:0]  prio;
    logic [7:0]  sa;
    logic [7:0]  da;
    logic        pdu1;
    logic [63:0] pay;
    logic [3:0]  cnt;
    logic [15:0] total;
    logic [47:0] t0;
  } result_s;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [28:0] frame_id = '0;
  logic is_extended = 0, is_error = 0, is_remote = 0;
  logic [3:0] frame_length = '0;
  logic [63:0] frame_data = '0;
  logic [47:0] timestamp_us = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic [23:0] pgn;
  logic [28:0] header_id;
  logic [2:0] priority_res;
  logic [7:0] source_address, dest_address;
  logic is_pdu1;
  logic [63:0] payload_bytes;
  logic [3:0] payload_count;
  logic [15:0] total_size;
  logic [47:0] start_time_us;

  j1939_transport_reassembler dut (.*);

  always #5 clk = ~clk;

  frame_s  pending_frames[$];
  result_s expected_results[$];

  // session table
  bit          s_open[256];
  logic [23:0] s_pgn[256];
  logic [15:0] s_size[256];
  logic [7:0]  s_pexp[256];
  logic [7:0]  s_pseen[256];
  logic [15:0] s_bseen[256];
  logic [28:0] s_hdr[256];
  logic [47:0] s_time[256];

  int mismatches = 0;
  int cycles = 0;
  bit quiet_phase = 0;
  bit hold_req = 0;
  bit stim_done = 0;

  function automatic void set_header(inout result_s r, input logic [28:0] h);
    r.hdr  = h;
    r.prio = h[28:26];
    r.sa   = h[7:0];
    r.da   = h[15:8];
  endfunction

  function automatic result_s reassemble(input frame_s f);
    result_s r;
    logic [7:0] pf, sa;
    logic [23:0] g;
    logic [3:0] n;
    r = '{st: jtr_pkg::ST_IGNORED, default: '0};
    if (f.err || f.rem || !f.ext) return r;
    pf = f.id[23:16];
    sa = f.id[7:0];
    g = {6'd0, f.id[25], f.id[24], pf, (pf >= jtr_pkg::PF_PDU2) ? f.id[15:8] : 8'd0};
    if (g == jtr_pkg::PGN_CM) begin
      if (f.len < 8) return r;
      if (f.data[7:0] != jtr_pkg::CTRL_BAM && f.data[7:0] != jtr_pkg::CTRL_RTS) return r;
      s_open[sa] = 1;
      s_size[sa] = f.data[23:8];
      s_pexp[sa] = f.data[31:24];
      s_pgn[sa] = f.data[63:40];
      s_pseen[sa] = 0;
      s_bseen[sa] = 0;
      s_hdr[sa] = f.id;
      s_time[sa] = f.ts;
      r.st = jtr_pkg::ST_STARTED;
      r.pgn = s_pgn[sa];
      set_header(r, f.id);
      r.t0 = f.ts;
    end else if (g == jtr_pkg::PGN_DT) begin
      bit fin;
      if (!s_open[sa]) return r;
      s_pseen[sa]++;
      for (int k = 1; k < 8 && s_bseen[sa] < s_size[sa]; k++) begin
        r.pay[8*r.cnt +: 8] = f.data[8*k +: 8];
        r.cnt++;
        s_bseen[sa]++;
      end
      fin = s_pseen[sa] >= s_pexp[sa] || s_bseen[sa] >= s_size[sa];
      r.st = fin ? jtr_pkg::ST_COMPLETE : jtr_pkg::ST_SEGMENT;
      r.pgn = s_pgn[sa];
      set_header(r, s_hdr[sa]);
      r.total = fin ? s_bseen[sa] : 16'd0;
      r.t0 = s_time[sa];
      if (fin) s_open[sa] = 0;
    end else begin
      n = (f.len > 8) ? 4'd8 : f.len;
      r.st = jtr_pkg::ST_SINGLE;
      r.pgn = g;
      set_header(r, f.id);
      r.pdu1 = pf < jtr_pkg::PF_PDU2;
      r.pay = (n == 8) ? f.data : (f.data & ((64'd1 << (8 * n)) - 1));
      r.cnt = n;
      r.total = {12'd0, n};
      r.t0 = f.ts;
    end
    return r;
  endfunction

  function automatic frame_s rand_frame();
    frame_s f;
    f.id   = 29'($urandom);
    f.ext  = ($urandom_range(0, 19) != 0);
    f.err  = ($urandom_range(0, 29) == 0);
    f.rem  = ($urandom_range(0, 29) == 0);
    f.len  = 4'($urandom_range(0, 15));
    f.data = {$urandom, $urandom};
    f.ts   = 48'({$urandom, $urandom});
    return f;
  endfunction

  function automatic frame_s tp_frame(input logic [23:0] g, input logic [7:0] sa,
                                      input logic [63:0] d, input logic [3:0] len);
    frame_s f;
    f = rand_frame();
    f.ext = 1;
    f.err = 0;
    f.rem = 0;
    f.id[25:8] = {2'b00, g[15:8], 8'($urandom)};
    f.id[7:0] = sa;
    f.data = d;
    f.len = len;
    return f;
  endfunction

  // one BAM/RTS session, well formed, with occasional breakage
  task automatic add_session(input logic [7:0] sa);
    logic [15:0] size;
    logic [7:0] pk;
    logic [63:0] d;
    size = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    pk = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'((size + 6) / 7);
    d = {$urandom, $urandom};
    d[7:0] = $urandom_range(0, 1) ? jtr_pkg::CTRL_BAM : jtr_pkg::CTRL_RTS;
    d[23:8] = size;
    d[31:24] = pk;
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_CM, sa, d, 4'($urandom_range(8, 15))));
    for (int i = 0; i < pk && i < 8; i++) begin
      if ($urandom_range(0, 14) == 0) pending_frames.push_back(rand_frame());
      pending_frames.push_back(tp_frame(jtr_pkg::PGN_DT, sa, {$urandom, $urandom},
                                        4'($urandom_range(0, 15))));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_results.push_back(reassemble(pending_frames.pop_front()));
      if (pending_frames.size() > 0 &&
          (quiet_phase || $urandom_range(0, 99) >= 9)) begin
        frame_s f;
        f = pending_frames[0];
        in_valid <= 1;
        frame_id <= f.id;
        is_extended <= f.ext;
        is_error <= f.err;
        is_remote <= f.rem;
        frame_length <= f.len;
        frame_data <= f.data;
        timestamp_us <= f.ts;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall, with a long hold-off on request
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 300;
      out_stall <= 1;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      if (hold_cnt == 1) hold_cnt <= -1;
      out_stall <= !quiet_phase && $urandom_range(0, 99) < 9;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", status);
      end else begin
        result_s e;
        e = expected_results.pop_front();
        if (status !== e.st || pgn !== e.pgn || header_id !== e.hdr ||
            priority_res !== e.prio || source_address !== e.sa ||
            dest_address !== e.da || is_pdu1 !== e.pdu1 || payload_bytes !== e.pay ||
            payload_count !== e.cnt || total_size !== e.total ||
            start_time_us !== e.t0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp st=%0d pgn=%h hdr=%h pr=%0d sa=%h da=%h p1=%b",
                     e.st, e.pgn, e.hdr, e.prio, e.sa, e.da, e.pdu1);
            $display("     exp pay=%h cnt=%0d tot=%0d t=%h",
                     e.pay, e.cnt, e.total, e.t0);
            $display("     got st=%0d pgn=%h hdr=%h pr=%0d sa=%h da=%h p1=%b",
                     status, pgn, header_id, priority_res, source_address,
                     dest_address, is_pdu1);
            $display("     got pay=%h cnt=%0d tot=%0d t=%h",
                     payload_bytes, payload_count, total_size, start_time_us);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_j1939_transport_reassembler: FAIL");
      $finish;
    end
  end

  initial begin
    frame_s f;
    logic [63:0] d;
    repeat (12) @(posedge clk);
    rst <= 0;
    // directed
    f = rand_frame(); f.ext = 0; f.err = 0; f.rem = 0; pending_frames.push_back(f);
    f = rand_frame(); f.ext = 1; f.err = 1; pending_frames.push_back(f);
    f = rand_frame(); f.ext = 1; f.err = 0; f.rem = 1; pending_frames.push_back(f);
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_DT, 8'h55, '1, 4'd8));
    d = {24'hFEF100, 8'hFF, 8'd2, 16'd10, jtr_pkg::CTRL_BAM};
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_CM, 8'h00, d, 4'd7));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_CM, 8'h00, {d[63:8], 8'd17}, 4'd8));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_CM, 8'hFF, d, 4'd15));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_DT, 8'hFF, 64'h0807060504030201, 4'd0));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_CM, 8'hFF,
                                      {d[63:8], jtr_pkg::CTRL_RTS}, 4'd8));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_DT, 8'hFF, '1, 4'd8));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_DT, 8'hFF, '0, 4'd8));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_CM, 8'h01,
                                      {24'hFFFFFF, 8'h0, 8'd0, 16'd0,
                                       jtr_pkg::CTRL_BAM}, 4'd8));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_DT, 8'h01, '1, 4'd8));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_CM, 8'h02,
                                      {24'h0, 8'h0, 8'd0, 16'hFFFF,
                                       jtr_pkg::CTRL_BAM}, 4'd8));
    pending_frames.push_back(tp_frame(jtr_pkg::PGN_DT, 8'h02, '1, 4'd8));
    f = tp_frame(jtr_pkg::PGN_CM, 8'h03, d, 4'd8); f.id[24] = 1; pending_frames.push_back(f);
    f = tp_frame(jtr_pkg::PGN_DT, 8'h03, d, 4'd8); f.id[25] = 1; pending_frames.push_back(f);
    f = rand_frame(); f.ext = 1; f.err = 0; f.rem = 0; f.id = '1; f.len = 4'd15;
    pending_frames.push_back(f);
    f.id = '0; f.len = 4'd0; f.data = '0; f.ts = '0; pending_frames.push_back(f);
    f.id = 29'h00F00000; f.len = 4'd3; f.data = '1; f.ts = '1; pending_frames.push_back(f);
    // random sessions interleaved with noise
    while (pending_frames.size() < 700) begin
      if ($urandom_range(0, 3) == 0) pending_frames.push_back(rand_frame());
      else add_session($urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom));
    end
    wait (pending_frames.size() < 400);
    hold_req = 1;
    wait (hold_cnt == -1);
    hold_req = 0;
    while (pending_frames.size() < 850) begin
      if ($urandom_range(0, 3) == 0) pending_frames.push_back(rand_frame());
      else add_session(8'($urandom_range(0, 7)));
    end
    wait (pending_frames.size() < 100);
    quiet_phase = 1;
    for (int i = 0; i < 200; i++) pending_frames.push_back(rand_frame());
    wait (pending_frames.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_j1939_transport_reassembler: PASS");
    else
      $display("tb_j1939_transport_reassembler: FAIL");
    $finish;
  end
endmodule
